[hw/rtl/box_average_downscale_rgb565_assert.svh]
// Assertion macros for the box average downscaler.
`ifndef BOX_AVERAGE_DOWNSCALE_RGB565_ASSERT_SVH
`define BOX_AVERAGE_DOWNSCALE_RGB565_ASSERT_SVH

// same-cycle implication
`define BADR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BADR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/badr_pkg.sv]
// Shared types, constants and tables of the box average downscaler.
package badr_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_STRIDE_DEF = 16;
   localparam int QUEUE_DEPTH    = 2;
   localparam int RECIP_SHIFT    = 24;

   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd2;
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd3;

   typedef struct packed {
      logic [11:0] w;
      logic [11:0] h;
      logic [10:0] sw;
      logic [10:0] sh;
   } dims_type;

   typedef struct packed {
      logic        first;
      logic        last;
      logic        emit;
      logic [4:0]  stride;
      logic [10:0] bx;
      logic [9:0]  col;
      logic [9:0]  row;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
   } cmd_type;

   typedef enum logic [2:0] {F_IDLE, F_SCALE, F_DIV, F_OFFSET, F_READY} front_state_type;
   typedef enum logic [1:0] {B_IDLE, B_ACC, B_MUL, B_OUT} back_state_type;

   // ceil(2^24 / (s*s)); exact quotient for 16-bit sums
   function automatic logic [24:0] recip(input logic [4:0] s);
      logic [24:0] m;
      case (s)
         5'd1:    m = 25'd16777216;
         5'd2:    m = 25'd4194304;
         5'd3:    m = 25'd1864136;
         5'd4:    m = 25'd1048576;
         5'd5:    m = 25'd671089;
         5'd6:    m = 25'd466034;
         5'd7:    m = 25'd342393;
         5'd8:    m = 25'd262144;
         5'd9:    m = 25'd207127;
         5'd10:   m = 25'd167773;
         5'd11:   m = 25'd138655;
         5'd12:   m = 25'd116509;
         5'd13:   m = 25'd99274;
         5'd14:   m = 25'd85599;
         5'd15:   m = 25'd74566;
         5'd16:   m = 25'd65536;
         default: m = 25'd16777216;
      endcase
      return m;
   endfunction

endpackage

[hw/rtl/badr_front.sv]
// Front end: frame setup, position counters and block classification.
module badr_front #(
   parameter int MAX_WIDTH  = badr_pkg::MAX_WIDTH_DEF,
   parameter int MAX_STRIDE = badr_pkg::MAX_STRIDE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_frame_start,
   input  logic [7:0]         req_red,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_blue,
   input  badr_pkg::dims_type dims,
   input  logic               full,
   output logic               push,
   output badr_pkg::cmd_type  cmd
);

   badr_pkg::front_state_type state_ff, state_in;
   badr_pkg::dims_type dims_ff, dims_in;
   logic [3:0]  step_ff, step_in;
   logic [14:0] accx_ff, accx_in, accy_ff, accy_in;
   logic [4:0]  cntx_ff, cntx_in, cnty_ff, cnty_in;
   logic [4:0]  stride_ff, stride_in;
   logic [9:0]  offset_ff, offset_in;
   logic [4:0]  rem_ff, rem_in;
   logic [11:0] quo_ff, quo_in;
   logic [10:0] col_ff, col_in, row_ff, row_in, bx_ff, bx_in, by_ff, by_in;
   logic [3:0]  jx_ff, jx_in, iy_ff, iy_in;

   logic        accept, clear_pos;
   logic [4:0]  smax;
   logic [5:0]  trial;
   logic [11:0] col_next, row_next, cols_diff;
   logic [16:0] xspan, yspan;
   logic [11:0] colsum;
   logic [10:0] row11;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= badr_pkg::F_IDLE;
         stride_ff <= 5'd1;
         offset_ff <= 10'd0;
         col_ff    <= '0;
         row_ff    <= '0;
         bx_ff     <= '0;
         by_ff     <= '0;
         jx_ff     <= '0;
         iy_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         stride_ff <= stride_in;
         offset_ff <= offset_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         bx_ff     <= bx_in;
         by_ff     <= by_in;
         jx_ff     <= jx_in;
         iy_ff     <= iy_in;
      end
      dims_ff <= dims_in;
      step_ff <= step_in;
      accx_ff <= accx_in;
      accy_ff <= accy_in;
      cntx_ff <= cntx_in;
      cnty_ff <= cnty_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   always_comb begin
      state_in  = state_ff;
      dims_in   = dims_ff;
      step_in   = step_ff;
      accx_in   = accx_ff;
      accy_in   = accy_ff;
      cntx_in   = cntx_ff;
      cnty_in   = cnty_ff;
      stride_in = stride_ff;
      offset_in = offset_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      clear_pos = 1'b0;
      smax      = 5'd0;
      trial     = 6'd0;
      cols_diff = 12'd0;
      req_stall = 1'b1;
      case (state_ff)
         badr_pkg::F_IDLE: begin
            req_stall = req_frame_start | full;
            if (req_valid && req_frame_start) begin
               dims_in  = dims;
               step_in  = 4'd0;
               accx_in  = '0;
               accy_in  = '0;
               cntx_in  = '0;
               cnty_in  = '0;
               state_in = badr_pkg::F_SCALE;
            end
         end
         badr_pkg::F_SCALE: begin
            accx_in = accx_ff + 15'(dims_ff.sw);
            accy_in = accy_ff + 15'(dims_ff.sh);
            if (accx_in <= 15'(dims_ff.w)) cntx_in = cntx_ff + 5'd1;
            if (accy_in <= 15'(dims_ff.h)) cnty_in = cnty_ff + 5'd1;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               smax = (cntx_in > cnty_in) ? cntx_in : cnty_in;
               if (smax == 5'd0) smax = 5'd1;
               if (smax > 5'(MAX_STRIDE)) smax = 5'(MAX_STRIDE);
               stride_in = smax;
               rem_in    = '0;
               quo_in    = dims_ff.w;
               step_in   = 4'd0;
               state_in  = badr_pkg::F_DIV;
            end
         end
         badr_pkg::F_DIV: begin
            trial = {rem_ff, quo_ff[11]};
            if (trial >= 6'(stride_ff)) begin
               rem_in = 5'(trial - 6'(stride_ff));
               quo_in = {quo_ff[10:0], 1'b1};
            end else begin
               rem_in = trial[4:0];
               quo_in = {quo_ff[10:0], 1'b0};
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd11) state_in = badr_pkg::F_OFFSET;
         end
         badr_pkg::F_OFFSET: begin
            cols_diff = 12'(dims_ff.sw) - quo_ff;
            offset_in = (12'(dims_ff.sw) > quo_ff) ? cols_diff[10:1] : 10'd0;
            clear_pos = 1'b1;
            state_in  = badr_pkg::F_READY;
         end
         badr_pkg::F_READY: begin
            req_stall = full;
            if (req_valid && !full) state_in = badr_pkg::F_IDLE;
         end
         default: state_in = badr_pkg::F_IDLE;
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      jx_in    = jx_ff;
      iy_in    = iy_ff;
      col_next = {1'b0, col_ff} + 12'd1;
      row_next = {1'b0, row_ff} + 12'd1;
      if (clear_pos) begin
         col_in = '0;
         row_in = '0;
         bx_in  = '0;
         by_in  = '0;
         jx_in  = '0;
         iy_in  = '0;
      end else if (accept) begin
         if (col_next >= dims.w) begin
            col_in = '0;
            bx_in  = '0;
            jx_in  = '0;
            if (row_next >= dims.h) begin
               row_in = '0;
               by_in  = '0;
               iy_in  = '0;
            end else begin
               row_in = row_next[10:0];
               if ({1'b0, iy_ff} + 5'd1 == stride_ff) begin
                  iy_in = '0;
                  by_in = by_ff + 11'd1;
               end else begin
                  iy_in = iy_ff + 4'd1;
               end
            end
         end else begin
            col_in = col_next[10:0];
            if ({1'b0, jx_ff} + 5'd1 == stride_ff) begin
               jx_in = '0;
               bx_in = bx_ff + 11'd1;
            end else begin
               jx_in = jx_ff + 4'd1;
            end
         end
      end
   end

   assign xspan  = 17'({1'b0, bx_ff} + 12'd1) * 17'(stride_ff);
   assign yspan  = 17'({1'b0, by_ff} + 12'd1) * 17'(stride_ff);
   assign colsum = 12'(bx_ff) + 12'(offset_ff);
   assign row11  = dims.sh - 11'd1 - by_ff;

   assign push = accept && (xspan <= 17'(dims.w)) && (yspan <= 17'(dims.h))
                 && (13'(bx_ff) < 13'(MAX_WIDTH));

   always_comb begin
      cmd.first  = (jx_ff == 4'd0) && (iy_ff == 4'd0);
      cmd.last   = ({1'b0, jx_ff} + 5'd1 == stride_ff) && ({1'b0, iy_ff} + 5'd1 == stride_ff);
      cmd.emit   = (colsum < 12'(dims.sw)) && (by_ff < dims.sh);
      cmd.stride = stride_ff;
      cmd.bx     = bx_ff;
      cmd.col    = colsum[9:0];
      cmd.row    = row11[9:0];
      cmd.r      = req_red;
      cmd.g      = req_green;
      cmd.b      = req_blue;
   end

endmodule

[hw/rtl/badr_queue.sv]
// Short command queue between front and back end.
module badr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  badr_pkg::cmd_type cmd_in,
   output logic              full,
   input  logic              pop,
   output badr_pkg::cmd_type cmd_out,
   output logic              empty
);

   localparam int PTR_W = $clog2(badr_pkg::QUEUE_DEPTH);

   badr_pkg::cmd_type entry_ff [badr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [PTR_W:0]   count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      end
      if (push) entry_ff[wr_ff] <= cmd_in;
   end

   assign full    = (count_ff == (PTR_W+1)'(badr_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign cmd_out = entry_ff[rd_ff];

endmodule

[hw/rtl/badr_back.sv]
// Back end: line store accumulate, block average and RGB565 result beat.
module badr_back #(
   parameter int MAX_WIDTH = badr_pkg::MAX_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  badr_pkg::cmd_type cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [9:0]        rsp_screen_col,
   output logic [9:0]        rsp_screen_row,
   output logic [15:0]       rsp_color
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic [47:0] sums_mem [MAX_WIDTH];

   badr_pkg::back_state_type state_ff, state_in;
   badr_pkg::cmd_type cmd_ff;
   logic [47:0] rdata_ff, sum_ff, sum_in;
   logic [15:0] qr_ff, qg_ff, qb_ff;
   logic [40:0] pr, pg, pb;
   logic [24:0] m;
   logic        rsp_valid_ff, out_free, load_out, wr_en;
   logic [9:0]  col_ff, row_ff;
   logic [15:0] color_ff, color_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      wr_en    = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         badr_pkg::B_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               state_in = badr_pkg::B_ACC;
            end
         end
         badr_pkg::B_ACC: begin
            wr_en    = 1'b1;
            state_in = (cmd_ff.last && cmd_ff.emit) ? badr_pkg::B_MUL : badr_pkg::B_IDLE;
         end
         badr_pkg::B_MUL: state_in = badr_pkg::B_OUT;
         badr_pkg::B_OUT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = badr_pkg::B_IDLE;
            end
         end
         default: state_in = badr_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      if (cmd_ff.first) begin
         sum_in = {8'd0, cmd_ff.r, 8'd0, cmd_ff.g, 8'd0, cmd_ff.b};
      end else begin
         sum_in[47:32] = rdata_ff[47:32] + 16'(cmd_ff.r);
         sum_in[31:16] = rdata_ff[31:16] + 16'(cmd_ff.g);
         sum_in[15:0]  = rdata_ff[15:0] + 16'(cmd_ff.b);
      end
   end

   assign m  = badr_pkg::recip(cmd_ff.stride);
   assign pr = 41'(sum_ff[47:32]) * 41'(m);
   assign pg = 41'(sum_ff[31:16]) * 41'(m);
   assign pb = 41'(sum_ff[15:0]) * 41'(m);

   assign color_in = {qr_ff[7:3], 11'd0} | {qg_ff[12:2], 5'd0} | {3'd0, qb_ff[15:3]};

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff   <= cmd;
         rdata_ff <= sums_mem[AW'(cmd.bx)];
      end
      if (wr_en) begin
         sums_mem[AW'(cmd_ff.bx)] <= sum_in;
         sum_ff <= sum_in;
      end
      if (state_ff == badr_pkg::B_MUL) begin
         qr_ff <= pr[badr_pkg::RECIP_SHIFT +: 16];
         qg_ff <= pg[badr_pkg::RECIP_SHIFT +: 16];
         qb_ff <= pb[badr_pkg::RECIP_SHIFT +: 16];
      end
      if (load_out) begin
         col_ff   <= cmd_ff.col;
         row_ff   <= cmd_ff.row;
         color_ff <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= badr_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_screen_col = col_ff;
   assign rsp_screen_row = row_ff;
   assign rsp_color      = color_ff;

endmodule

[hw/rtl/box_average_downscale_rgb565.sv]
// Top level of the box average downscaler: register port and front/queue/back.
// RGB888 pixels come in raster order; each completed stride x stride block on screen
// yields one RGB565 beat at its flipped, centered screen position. The back end pops a
// pixel, then adds it into the single-port line store by read-modify-write (and, when
// it closes an on-screen block, multiplies and outputs the average, held by a stalled
// response); it takes no new pixel until done with the last. A frame_start pixel is held
// while the stride is found (16 scale steps, 12 divide steps for the centering width, then offset).
module box_average_downscale_rgb565 #(
   parameter int MAX_WIDTH  = badr_pkg::MAX_WIDTH_DEF,
   parameter int MAX_STRIDE = badr_pkg::MAX_STRIDE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_frame_start,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_screen_col,
   output logic [9:0]  rsp_screen_row,
   output logic [15:0] rsp_color,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [11:0] image_width_ff, image_height_ff;
   logic [10:0] screen_width_ff, screen_height_ff;
   logic        csr_write;
   badr_pkg::dims_type dims;
   logic        push, full, pop, empty;
   badr_pkg::cmd_type cmd_push, cmd_pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= 12'd320;
         image_height_ff  <= 12'd240;
         screen_width_ff  <= 11'd320;
         screen_height_ff <= 11'd240;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            badr_pkg::REG_IMAGE_WIDTH:   image_width_ff   <= csr_pwdata[11:0];
            badr_pkg::REG_IMAGE_HEIGHT:  image_height_ff  <= csr_pwdata[11:0];
            badr_pkg::REG_SCREEN_WIDTH:  screen_width_ff  <= csr_pwdata[10:0];
            badr_pkg::REG_SCREEN_HEIGHT: screen_height_ff <= csr_pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         badr_pkg::REG_IMAGE_WIDTH:   csr_prdata = 32'(image_width_ff);
         badr_pkg::REG_IMAGE_HEIGHT:  csr_prdata = 32'(image_height_ff);
         badr_pkg::REG_SCREEN_WIDTH:  csr_prdata = 32'(screen_width_ff);
         badr_pkg::REG_SCREEN_HEIGHT: csr_prdata = 32'(screen_height_ff);
         default:                     csr_prdata = 32'd0;
      endcase
   end

   // zero acts as one, large values saturate
   always_comb begin
      dims.w  = (image_width_ff == 12'd0) ? 12'd1 :
                (image_width_ff > 12'd2048) ? 12'd2048 : image_width_ff;
      dims.h  = (image_height_ff == 12'd0) ? 12'd1 :
                (image_height_ff > 12'd2048) ? 12'd2048 : image_height_ff;
      dims.sw = (screen_width_ff == 11'd0) ? 11'd1 :
                (screen_width_ff > 11'd1024) ? 11'd1024 : screen_width_ff;
      dims.sh = (screen_height_ff == 11'd0) ? 11'd1 :
                (screen_height_ff > 11'd1024) ? 11'd1024 : screen_height_ff;
   end

   badr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_STRIDE (MAX_STRIDE)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_frame_start (req_frame_start),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .dims            (dims),
      .full            (full),
      .push            (push),
      .cmd             (cmd_push)
   );

   badr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .cmd_in  (cmd_push),
      .full    (full),
      .pop     (pop),
      .cmd_out (cmd_pop),
      .empty   (empty)
   );

   badr_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .empty          (empty),
      .cmd            (cmd_pop),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_screen_col (rsp_screen_col),
      .rsp_screen_row (rsp_screen_row),
      .rsp_color      (rsp_color)
   );

endmodule

[hw/rtl/badr_checker.sv]
// Port-level assertion checker for the box average downscaler, with its bind.
`include "box_average_downscale_rgb565_assert.svh"

module badr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_frame_start,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [9:0]  rsp_screen_col,
   input logic [9:0]  rsp_screen_row,
   input logic [15:0] rsp_color,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [3:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   logic wr;
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   `BADR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp beat dropped while stalled")

   `BADR_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_color) && $stable(rsp_screen_col) && $stable(rsp_screen_row), "stalled rsp beat changed")

   `BADR_ASSERT_NOW(a_frame_setup, clock, reset, req_valid && req_frame_start && !req_stall, $past(req_stall), "frame start beat taken without setup")

   `BADR_ASSERT_NOW(a_csr_readback, clock, reset, $past(wr) && csr_psel && !csr_pwrite && csr_paddr == $past(csr_paddr), csr_prdata[10:0] == $past(csr_pwdata[10:0]), "register readback mismatch")

endmodule

bind box_average_downscale_rgb565 badr_checker u_badr_checker (.*);
